// ----- hw/rtl/vmr_pkg.sv -----
`timescale 1ns / 1ps

package vmr_pkg;

  localparam int VMR_QUEUE_SIZE = 256;

  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  localparam logic [11:0] OFF_MAGIC        = 12'h000;
  localparam logic [11:0] OFF_VERSION      = 12'h004;
  localparam logic [11:0] OFF_DEVICE_ID    = 12'h008;
  localparam logic [11:0] OFF_VENDOR_ID    = 12'h00C;
  localparam logic [11:0] OFF_DEV_FEAT     = 12'h010;
  localparam logic [11:0] OFF_DEV_FEAT_SEL = 12'h014;
  localparam logic [11:0] OFF_DRV_FEAT     = 12'h020;
  localparam logic [11:0] OFF_DRV_FEAT_SEL = 12'h024;
  localparam logic [11:0] OFF_QSEL         = 12'h030;
  localparam logic [11:0] OFF_QNUM_MAX     = 12'h034;
  localparam logic [11:0] OFF_QNUM         = 12'h038;
  localparam logic [11:0] OFF_QREADY       = 12'h044;
  localparam logic [11:0] OFF_QNOTIFY      = 12'h050;
  localparam logic [11:0] OFF_IRQ_STATUS   = 12'h060;
  localparam logic [11:0] OFF_IRQ_ACK      = 12'h064;
  localparam logic [11:0] OFF_STATUS       = 12'h070;
  localparam logic [11:0] OFF_DESC_LO      = 12'h080;
  localparam logic [11:0] OFF_DESC_HI      = 12'h084;
  localparam logic [11:0] OFF_AVAIL_LO     = 12'h090;
  localparam logic [11:0] OFF_AVAIL_HI     = 12'h094;
  localparam logic [11:0] OFF_USED_LO      = 12'h0A0;
  localparam logic [11:0] OFF_USED_HI      = 12'h0A4;
  localparam logic [11:0] OFF_CONFIG_GEN   = 12'h0FC;

  localparam logic [31:0] MAGIC_VALUE   = 32'h7472_6976;
  localparam logic [31:0] VENDOR_VALUE  = 32'h554D_4551;
  localparam logic [31:0] VERSION_VALUE = 32'd2;
  localparam logic [31:0] DEVICE_VALUE  = 32'd3;
  localparam logic [63:0] FEATURE_RESET = 64'h0000_0001_0000_0000;

endpackage

// ----- hw/rtl/vmr_if.sv -----
`timescale 1ns / 1ps

interface vmr_in_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [11:0] offset;
  logic [31:0] write_data;

  modport source (output valid, opcode, offset, write_data, input ready);
  modport sink   (input valid, opcode, offset, write_data, output ready);
endinterface

interface vmr_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] read_data;
  logic        notify_tx;
  logic        irq_pending;

  modport source (output valid, read_data, notify_tx, irq_pending, input ready);
  modport sink   (input valid, read_data, notify_tx, irq_pending, output ready);
endinterface

// ----- hw/rtl/virtio_mmio_register_file.sv -----
// Each input transfer's result is registered in the output register.
// Throughput: one access per cycle while the sink takes results; the single output
// register refills in the cycle it is drained, so input ready follows output ready.
// Reset (rst_n low, synchronous): output register empty, feature word holds the
// version 1 bit, all selects, queues and status registers cleared.
`timescale 1ns / 1ps

module virtio_mmio_register_file #(
  parameter int QUEUE_SIZE = vmr_pkg::VMR_QUEUE_SIZE
) (
  input logic        clk,
  input logic        rst_n,
  vmr_in_if.sink     in_bus,
  vmr_out_if.source  out_bus
);
  import vmr_pkg::*;

  localparam logic [31:0] QSIZE_WORD = 32'(QUEUE_SIZE);

  logic [63:0] feature_r;
  logic [31:0] dev_sel_r;
  logic [31:0] drv_sel_r;
  logic [31:0] queue_sel_r;
  logic        q_ready_r [2];
  logic [15:0] q_len_r   [2];
  logic [63:0] q_desc_r  [2];
  logic [63:0] q_avail_r [2];
  logic [63:0] q_used_r  [2];
  logic [31:0] irq_r;
  logic [31:0] status_r;

  logic        out_valid_r;
  logic [31:0] read_data_r;
  logic        notify_r;
  logic        irq_pend_r;

  logic        accept;
  logic        is_write;
  logic        qok;
  logic        q;
  logic [31:0] wdata;
  logic [31:0] rd_nxt;
  logic        notify_nxt;
  logic [31:0] irq_nxt;
  logic        tx_live;

  assign in_bus.ready = !out_valid_r || out_bus.ready;
  assign accept       = in_bus.valid && in_bus.ready;
  assign is_write     = (in_bus.opcode == OP_WRITE);
  assign wdata        = in_bus.write_data;
  assign qok          = (queue_sel_r[31:1] == 31'd0);
  assign q            = queue_sel_r[0];
  assign tx_live      = q_ready_r[1] && (q_desc_r[1] != 64'd0) &&
                        (q_avail_r[1] != 64'd0) && (q_used_r[1] != 64'd0);

  always_comb begin
    rd_nxt = 32'd0;
    if (!is_write) begin
      unique case (in_bus.offset)
        OFF_MAGIC:      rd_nxt = MAGIC_VALUE;
        OFF_VERSION:    rd_nxt = VERSION_VALUE;
        OFF_DEVICE_ID:  rd_nxt = DEVICE_VALUE;
        OFF_VENDOR_ID:  rd_nxt = VENDOR_VALUE;
        OFF_DEV_FEAT: begin
          if (dev_sel_r == 32'd0) begin
            rd_nxt = feature_r[31:0];
          end else if (dev_sel_r == 32'd1) begin
            rd_nxt = feature_r[63:32];
          end
        end
        OFF_QNUM_MAX:   rd_nxt = QSIZE_WORD;
        OFF_QREADY:     rd_nxt = {31'd0, qok && q_ready_r[q]};
        OFF_IRQ_STATUS: rd_nxt = irq_r;
        OFF_STATUS:     rd_nxt = status_r;
        OFF_CONFIG_GEN: rd_nxt = 32'd0;
        default:        rd_nxt = 32'd0;
      endcase
    end
  end

  // Interrupt status after this access; feeds both the register and irq_pending.
  always_comb begin
    irq_nxt    = irq_r;
    notify_nxt = 1'b0;
    if (is_write) begin
      unique case (in_bus.offset)
        OFF_QNOTIFY: begin
          if (wdata == 32'd1) begin
            notify_nxt = 1'b1;
            if (tx_live) begin
              irq_nxt = irq_r | 32'd1;
            end
          end
        end
        OFF_IRQ_ACK: irq_nxt = irq_r & ~wdata;
        OFF_STATUS: begin
          if (wdata == 32'd0) begin
            irq_nxt = 32'd0;
          end
        end
        default: irq_nxt = irq_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      feature_r   <= FEATURE_RESET;
      dev_sel_r   <= 32'd0;
      drv_sel_r   <= 32'd0;
      queue_sel_r <= 32'd0;
      irq_r       <= 32'd0;
      status_r    <= 32'd0;
      for (int i = 0; i < 2; i++) begin
        q_ready_r[i] <= 1'b0;
        q_len_r[i]   <= 16'd0;
        q_desc_r[i]  <= 64'd0;
        q_avail_r[i] <= 64'd0;
        q_used_r[i]  <= 64'd0;
      end
    end else if (accept) begin
      irq_r <= irq_nxt;
      if (is_write) begin
        unique case (in_bus.offset)
          OFF_DEV_FEAT_SEL: dev_sel_r <= wdata;
          OFF_DRV_FEAT_SEL: drv_sel_r <= wdata;
          OFF_DRV_FEAT: begin
            if (drv_sel_r == 32'd0) begin
              feature_r[31:0] <= wdata;
            end else if (drv_sel_r == 32'd1) begin
              feature_r[63:32] <= wdata;
            end
          end
          OFF_QSEL: queue_sel_r <= wdata;
          OFF_QNUM: begin
            if (qok) begin
              // clamp to the maximum queue size
              q_len_r[q] <= (wdata < QSIZE_WORD) ? wdata[15:0] : QSIZE_WORD[15:0];
            end
          end
          OFF_QREADY: begin
            if (qok) begin
              q_ready_r[q] <= (wdata != 32'd0);
            end
          end
          OFF_STATUS: begin
            status_r <= wdata;
            if (wdata == 32'd0) begin
              for (int i = 0; i < 2; i++) begin
                q_ready_r[i] <= 1'b0;
                q_len_r[i]   <= 16'd0;
                q_desc_r[i]  <= 64'd0;
                q_avail_r[i] <= 64'd0;
                q_used_r[i]  <= 64'd0;
              end
            end
          end
          OFF_DESC_LO:  if (qok) q_desc_r[q][31:0]   <= wdata;
          OFF_DESC_HI:  if (qok) q_desc_r[q][63:32]  <= wdata;
          OFF_AVAIL_LO: if (qok) q_avail_r[q][31:0]  <= wdata;
          OFF_AVAIL_HI: if (qok) q_avail_r[q][63:32] <= wdata;
          OFF_USED_LO:  if (qok) q_used_r[q][31:0]   <= wdata;
          OFF_USED_HI:  if (qok) q_used_r[q][63:32]  <= wdata;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_bus.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // hold the result while the sink stalls
  always_ff @(posedge clk) begin
    if (accept) begin
      read_data_r <= rd_nxt;
      notify_r    <= notify_nxt;
      irq_pend_r  <= (irq_nxt != 32'd0);
    end
  end

  assign out_bus.valid       = out_valid_r;
  assign out_bus.read_data   = read_data_r;
  assign out_bus.notify_tx   = notify_r;
  assign out_bus.irq_pending = irq_pend_r;

endmodule

// ----- hw/rtl/vmr_checker.sv -----
`timescale 1ns / 1ps

module vmr_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_read_data,
  input logic        out_notify_tx
);

  // a stalled result stays on the port
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // every input transfer yields a result in the next cycle
  a_in_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("input transfer produced no result");

  // an empty output register never blocks the input
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  // a notify comes only from a write, which returns no read data
  a_notify_no_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_notify_tx |-> out_read_data == 32'd0)
    else $error("notify with nonzero read data");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind virtio_mmio_register_file vmr_checker u_vmr_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_bus.valid),
  .in_ready      (in_bus.ready),
  .out_valid     (out_bus.valid),
  .out_ready     (out_bus.ready),
  .out_read_data (out_bus.read_data),
  .out_notify_tx (out_bus.notify_tx)
);

// ----- bench/tb_virtio_mmio_register_file.sv -----
`timescale 1ns / 1ps

module tb_virtio_mmio_register_file;
  import vmr_pkg::*;

  typedef struct packed {
    logic [31:0] read_data;
    logic        notify_tx;
    logic        irq_pending;
  } mmio_result_t;

  class mmio_scoreboard;
    logic [63:0]  feature_word;
    logic [31:0]  dev_fsel;
    logic [31:0]  drv_fsel;
    logic [31:0]  qsel;
    logic         q_ready [2];
    logic [15:0]  q_len [2];
    logic [63:0]  desc_addr [2];
    logic [63:0]  avail_addr [2];
    logic [63:0]  used_addr [2];
    logic [31:0]  irq_status;
    logic [31:0]  dev_status;
    mmio_result_t pending_results[$];
    int           failures;
    int           results_seen;

    function new();
      failures = 0;
      results_seen = 0;
      feature_word = FEATURE_RESET;
      dev_fsel = '0;
      drv_fsel = '0;
      qsel = '0;
      irq_status = '0;
      dev_status = '0;
      clear_queues();
    endfunction

    function void clear_queues();
      for (int i = 0; i < 2; i++) begin
        q_ready[i] = 1'b0;
        q_len[i] = '0;
        desc_addr[i] = '0;
        avail_addr[i] = '0;
        used_addr[i] = '0;
      end
    endfunction

    // Update the register image for one accepted access and queue its result.
    function void note_access(logic op, logic [11:0] off, logic [31:0] v);
      mmio_result_t r;
      logic qok;
      int   qi;
      r = '0;
      qok = (qsel < 2);
      qi = int'(qsel[0]);
      if (op == OP_READ) begin
        case (off)
          OFF_MAGIC:      r.read_data = MAGIC_VALUE;
          OFF_VERSION:    r.read_data = VERSION_VALUE;
          OFF_DEVICE_ID:  r.read_data = DEVICE_VALUE;
          OFF_VENDOR_ID:  r.read_data = VENDOR_VALUE;
          OFF_DEV_FEAT: begin
            if (dev_fsel == 0) r.read_data = feature_word[31:0];
            else if (dev_fsel == 1) r.read_data = feature_word[63:32];
          end
          OFF_QNUM_MAX:   r.read_data = 32'(VMR_QUEUE_SIZE);
          OFF_QREADY:     r.read_data = {31'b0, qok && q_ready[qi]};
          OFF_IRQ_STATUS: r.read_data = irq_status;
          OFF_STATUS:     r.read_data = dev_status;
          default: ;
        endcase
      end else begin
        case (off)
          OFF_DEV_FEAT_SEL: dev_fsel = v;
          OFF_DRV_FEAT_SEL: drv_fsel = v;
          OFF_DRV_FEAT: begin
            if (drv_fsel == 0) feature_word[31:0] = v;
            else if (drv_fsel == 1) feature_word[63:32] = v;
          end
          OFF_QSEL: qsel = v;
          OFF_QNUM: if (qok) q_len[qi] = (v < VMR_QUEUE_SIZE) ? v[15:0] : 16'(VMR_QUEUE_SIZE);
          OFF_QREADY: if (qok) q_ready[qi] = (v != 0);
          OFF_QNOTIFY: begin
            if (v == 1) begin
              r.notify_tx = 1'b1;
              if (q_ready[1] && desc_addr[1] != 0 && avail_addr[1] != 0 && used_addr[1] != 0)
                irq_status[0] = 1'b1;
            end
          end
          OFF_IRQ_ACK: irq_status &= ~v;
          OFF_STATUS: begin
            dev_status = v;
            if (v == 0) begin
              clear_queues();
              irq_status = '0;
            end
          end
          OFF_DESC_LO:  if (qok) desc_addr[qi][31:0] = v;
          OFF_DESC_HI:  if (qok) desc_addr[qi][63:32] = v;
          OFF_AVAIL_LO: if (qok) avail_addr[qi][31:0] = v;
          OFF_AVAIL_HI: if (qok) avail_addr[qi][63:32] = v;
          OFF_USED_LO:  if (qok) used_addr[qi][31:0] = v;
          OFF_USED_HI:  if (qok) used_addr[qi][63:32] = v;
          default: ;
        endcase
      end
      r.irq_pending = (irq_status != 0);
      pending_results.push_back(r);
    endfunction

    function void check_result(logic [31:0] rd, logic ntf, logic irq);
      mmio_result_t want;
      results_seen++;
      if (pending_results.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("unexpected result: read_data=%h notify_tx=%b irq_pending=%b",
                   rd, ntf, irq);
        return;
      end
      want = pending_results.pop_front();
      if (want.read_data !== rd || want.notify_tx !== ntf || want.irq_pending !== irq) begin
        failures++;
        if (failures <= 10)
          $display({"result %0d mismatch: read_data exp %h got %h, ",
                    "notify_tx exp %b got %b, irq_pending exp %b got %b"},
                   results_seen, want.read_data, rd, want.notify_tx, ntf,
                   want.irq_pending, irq);
      end
    endfunction
  endclass

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int STALL_CYCLES   = 400;
  localparam int RANDOM_ITEMS   = 600;

  localparam logic [11:0] REG_OFFSETS [23] = '{
    OFF_MAGIC, OFF_VERSION, OFF_DEVICE_ID, OFF_VENDOR_ID, OFF_DEV_FEAT, OFF_DEV_FEAT_SEL,
    OFF_DRV_FEAT, OFF_DRV_FEAT_SEL, OFF_QSEL, OFF_QNUM_MAX, OFF_QNUM, OFF_QREADY,
    OFF_QNOTIFY, OFF_IRQ_STATUS, OFF_IRQ_ACK, OFF_STATUS, OFF_DESC_LO, OFF_DESC_HI,
    OFF_AVAIL_LO, OFF_AVAIL_HI, OFF_USED_LO, OFF_USED_HI, OFF_CONFIG_GEN
  };

  logic clk = 1'b0;
  logic rst_n;
  bit   no_gaps = 1'b0;
  int   items_sent = 0;
  int   quiet_cycles = 0;

  mmio_scoreboard sb = new();

  vmr_in_if  in_bus();
  vmr_out_if out_bus();

  virtio_mmio_register_file u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus)
  );

  always #1 clk = ~clk;

  // Both transfers are sampled with pre-edge values.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_bus.valid && out_bus.ready)
        sb.check_result(out_bus.read_data, out_bus.notify_tx, out_bus.irq_pending);
      if (in_bus.valid && in_bus.ready)
        sb.note_access(in_bus.opcode, in_bus.offset, in_bus.write_data);
    end
  end

  always @(posedge clk) begin
    if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) || !rst_n) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("tb_virtio_mmio_register_file NOT OK");
        $finish;
      end
    end
  end

  // Result side: random back-pressure, plus one long hold so the block backs up.
  initial begin
    bit held;
    held = 1'b0;
    out_bus.ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      @(posedge clk);
      if (!held && sb.results_seen >= 200) begin
        held = 1'b1;
        out_bus.ready <= 1'b0;
        repeat (STALL_CYCLES) @(posedge clk);
      end else begin
        out_bus.ready <= no_gaps || ($urandom_range(99) >= 30);
      end
    end
  end

  task automatic send_access(input logic op, input logic [11:0] off, input logic [31:0] v);
    if (!no_gaps && $urandom_range(99) < 30) begin
      in_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 2)) @(posedge clk);
    end
    in_bus.valid      <= 1'b1;
    in_bus.opcode     <= op;
    in_bus.offset     <= off;
    in_bus.write_data <= v;
    do @(posedge clk); while (!in_bus.ready);
    items_sent++;
  endtask

  function automatic logic [31:0] pick_data();
    case ($urandom_range(7))
      0: return 32'h0;
      1: return 32'h1;
      2: return 32'hFFFF_FFFF;
      3: return $urandom_range(3);
      4: return VMR_QUEUE_SIZE - 1 + $urandom_range(2);
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [11:0] pick_offset();
    int r;
    r = $urandom_range(99);
    if (r < 75) return REG_OFFSETS[$urandom_range(22)];
    if (r < 88) return 12'($urandom_range(63) * 4);
    return 12'($urandom());
  endfunction

  function automatic logic [31:0] pick_select();
    int r;
    r = $urandom_range(99);
    if (r < 45) return 32'd1;
    if (r < 80) return 32'd0;
    return pick_data();
  endfunction

  function automatic logic [31:0] pick_addr_half();
    return ($urandom_range(9) == 0) ? 32'h0 : $urandom();
  endfunction

  // Typical driver bring-up of one queue followed by a kick and, sometimes, an acknowledge.
  task automatic queue_bringup();
    send_access(OP_WRITE, OFF_STATUS, $urandom_range(1, 255));
    send_access(OP_WRITE, OFF_QSEL, ($urandom_range(99) < 70) ? 32'd1 : pick_select());
    send_access(OP_WRITE, OFF_QNUM, pick_data());
    send_access(OP_WRITE, OFF_DESC_LO, pick_addr_half());
    send_access(OP_WRITE, OFF_DESC_HI, pick_addr_half());
    send_access(OP_WRITE, OFF_AVAIL_LO, pick_addr_half());
    send_access(OP_WRITE, OFF_AVAIL_HI, pick_addr_half());
    send_access(OP_WRITE, OFF_USED_LO, pick_addr_half());
    send_access(OP_WRITE, OFF_USED_HI, pick_addr_half());
    send_access(OP_WRITE, OFF_QREADY, ($urandom_range(9) != 0) ? 32'd1 : pick_data());
    send_access(OP_READ, OFF_QREADY, $urandom());
    send_access(OP_WRITE, OFF_QNOTIFY, ($urandom_range(99) < 85) ? 32'd1 : pick_data());
    send_access(OP_READ, OFF_IRQ_STATUS, $urandom());
    if ($urandom_range(1))
      send_access(OP_WRITE, OFF_IRQ_ACK, pick_data());
  endtask

  task automatic feature_exchange();
    logic [31:0] half;
    half = pick_select();
    send_access(OP_WRITE, OFF_DRV_FEAT_SEL, half);
    send_access(OP_WRITE, OFF_DRV_FEAT, $urandom());
    send_access(OP_WRITE, OFF_DEV_FEAT_SEL, ($urandom_range(3) == 0) ? pick_select() : half);
    send_access(OP_READ, OFF_DEV_FEAT, $urandom());
  endtask

  initial begin
    int r;
    rst_n             <= 1'b0;
    in_bus.valid      <= 1'b0;
    in_bus.opcode     <= OP_READ;
    in_bus.offset     <= '0;
    in_bus.write_data <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Identification, feature halves and select range.
    send_access(OP_READ, OFF_MAGIC, 32'hFFFF_FFFF);
    send_access(OP_READ, OFF_VERSION, 32'h0);
    send_access(OP_READ, OFF_DEVICE_ID, 32'h0);
    send_access(OP_READ, OFF_VENDOR_ID, 32'h0);
    send_access(OP_READ, OFF_DEV_FEAT, 32'h0);
    send_access(OP_WRITE, OFF_DEV_FEAT_SEL, 32'd1);
    send_access(OP_READ, OFF_DEV_FEAT, 32'h0);
    send_access(OP_WRITE, OFF_DEV_FEAT_SEL, 32'hFFFF_FFFF);
    send_access(OP_READ, OFF_DEV_FEAT, 32'h0);
    send_access(OP_WRITE, OFF_DRV_FEAT_SEL, 32'd7);
    send_access(OP_WRITE, OFF_DRV_FEAT, 32'hFFFF_FFFF);
    send_access(OP_WRITE, OFF_DRV_FEAT_SEL, 32'd0);
    send_access(OP_WRITE, OFF_DRV_FEAT, 32'hFFFF_FFFF);
    send_access(OP_READ, OFF_QNUM_MAX, 32'h0);
    // Queue 1 bring-up with clamped size, then a notify that raises the interrupt.
    send_access(OP_WRITE, OFF_QSEL, 32'd1);
    send_access(OP_WRITE, OFF_QNUM, 32'hFFFF_FFFF);
    send_access(OP_WRITE, OFF_DESC_LO, 32'h0000_1000);
    send_access(OP_WRITE, OFF_AVAIL_HI, 32'hFFFF_FFFF);
    send_access(OP_WRITE, OFF_USED_LO, 32'h0000_3000);
    send_access(OP_WRITE, OFF_QREADY, 32'd1);
    send_access(OP_WRITE, OFF_QNOTIFY, 32'd1);
    send_access(OP_READ, OFF_IRQ_STATUS, 32'h0);
    send_access(OP_WRITE, OFF_QNOTIFY, 32'd2);
    send_access(OP_WRITE, OFF_IRQ_ACK, 32'hFFFF_FFFF);
    // Out-of-range queue select, status clear, unmapped and write-only offsets.
    send_access(OP_WRITE, OFF_QSEL, 32'd2);
    send_access(OP_WRITE, OFF_QREADY, 32'd1);
    send_access(OP_READ, OFF_QREADY, 32'h0);
    send_access(OP_WRITE, OFF_STATUS, 32'h0);
    send_access(OP_READ, OFF_QNUM, 32'h0);
    send_access(OP_READ, 12'hFFF, 32'h0);
    send_access(OP_WRITE, 12'h001, 32'hFFFF_FFFF);

    while (items_sent < 31 + RANDOM_ITEMS) begin
      no_gaps = (items_sent >= 450 && items_sent < 560);
      r = $urandom_range(99);
      if (r < 30) queue_bringup();
      else if (r < 40) feature_exchange();
      else send_access(1'($urandom_range(1)), pick_offset(), pick_data());
    end
    in_bus.valid <= 1'b0;
    no_gaps = 1'b0;

    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
    if (sb.failures == 0 && sb.pending_results.size() == 0)
      $display("tb_virtio_mmio_register_file OK");
    else
      $display("tb_virtio_mmio_register_file NOT OK");
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/vmr_pkg.sv
hw/rtl/vmr_if.sv
hw/rtl/virtio_mmio_register_file.sv
hw/rtl/vmr_checker.sv
bench/tb_virtio_mmio_register_file.sv
